// ----- sv/srel_pkg.sv -----
// Shared types and codes for the set relation classifier.
`default_nettype none
package srel_pkg;
    localparam int ElemWidth = 32;
    localparam int RelWidth  = 3;

    typedef enum logic [RelWidth-1:0] {
        REL_EQUAL    = 3'd0,
        REL_B_IN_A   = 3'd1,
        REL_A_IN_B   = 3'd2,
        REL_DISJOINT = 3'd3,
        REL_CONFUSED = 3'd4
    } relation_t;

    typedef struct packed {
        logic [ElemWidth-1:0] element;
        logic                 in_second_set;
        logic                 has_element;
        logic                 end_of_pair;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_INSERT,
        ST_FINISH
    } back_state_t;
endpackage
`default_nettype wire

// ----- sv/srel_if.sv -----
// Valid/ready channel interfaces for input items and results.
`default_nettype none
interface srel_item_if;
    logic        valid;
    logic        ready;
    logic [31:0] element;
    logic        in_second_set;
    logic        has_element;
    logic        end_of_pair;
    modport source (output valid, element, in_second_set, has_element, end_of_pair,
                    input ready);
    modport sink (input valid, element, in_second_set, has_element, end_of_pair,
                  output ready);
endinterface

interface srel_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] relation;
    logic       overflowed;
    modport source (output valid, relation, overflowed, input ready);
    modport sink (input valid, relation, overflowed, output ready);
endinterface
`default_nettype wire

// ----- sv/srel_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module srel_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- sv/srel_front.sv -----
// Front end: accept input words, drop empty non-closing words, queue commands.
`default_nettype none
module srel_front
    import srel_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    srel_item_if.sink  items,
    output logic       cmd_valid,
    output cmd_t       cmd,
    input  wire logic  cmd_pop
);
    cmd_t        q_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push;
    logic        do_pop;
    cmd_t        in_cmd;

    assign items.ready = (cnt_reg != 2'd2);
    assign in_cmd = '{element: items.element, in_second_set: items.in_second_set,
                      has_element: items.has_element, end_of_pair: items.end_of_pair};
    assign push   = items.valid && items.ready && (items.has_element || items.end_of_pair);
    assign do_pop = cmd_pop && (cnt_reg != 2'd0);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue count out of range");
    a_full_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 && !cmd_pop |=> cnt_reg == 2'd2)
        else $error("full queue lost an entry");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd0 && push |=> cmd_valid)
        else $error("pushed command not visible");
endmodule
`default_nettype wire

// ----- sv/srel_back.sv -----
// Back end: table search and insert, set counts, classification and result register.
`default_nettype none
module srel_back
    import srel_pkg::*;
#(
    parameter int TABLE_CAPACITY = 128,
    parameter int COUNT_LIMIT    = 255
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    cmd_valid,
    input  wire cmd_t    cmd,
    output logic         cmd_pop,
    srel_result_if.source results
);
    localparam int AW = $clog2(TABLE_CAPACITY);
    localparam int FW = $clog2(TABLE_CAPACITY + 1);
    localparam int CW = $clog2(COUNT_LIMIT + 1);
    localparam logic [CW-1:0] LIMIT = CW'(COUNT_LIMIT);
    localparam logic [FW-1:0] CAP   = FW'(TABLE_CAPACITY);

    back_state_t     state_reg, state_next;
    cmd_t            cur_reg, cur_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic [FW-1:0]   fill_reg, fill_next;
    logic [CW-1:0]   cf_reg, cf_next, cs_reg, cs_next, cu_reg, cu_next;
    logic            ovf_reg, ovf_next;
    logic            ovalid_reg, ovalid_next;
    relation_t       rel_reg, rel_next;
    logic            oovf_reg, oovf_next;
    logic            ram_we;
    logic [ElemWidth-1:0] rdata;
    logic            match;
    logic            scan_last;
    logic            can_emit;
    logic            table_full;
    relation_t       rel_calc;

    srel_ram #(.WIDTH(ElemWidth), .DEPTH(TABLE_CAPACITY)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_reg[AW-1:0]),
        .wdata (cur_reg.element),
        .raddr (idx_next),
        .rdata (rdata)
    );

    assign match      = (rdata == cur_reg.element);
    assign scan_last  = ({1'b0, idx_reg} + (AW+1)'(1)) == (AW+1)'(fill_reg);
    assign can_emit   = !ovalid_reg || results.ready;
    assign table_full = (fill_reg == CAP) || (cu_reg >= LIMIT);

    assign results.valid      = ovalid_reg;
    assign results.relation   = rel_reg;
    assign results.overflowed = oovf_reg;

    always_comb
    begin
        if (cf_reg == cs_reg && cs_reg == cu_reg)
            rel_calc = REL_EQUAL;
        else if (cu_reg == cf_reg && cs_reg < cf_reg)
            rel_calc = REL_B_IN_A;
        else if (cu_reg == cs_reg && cf_reg < cs_reg)
            rel_calc = REL_A_IN_B;
        else if (({1'b0, cf_reg} + {1'b0, cs_reg}) == {1'b0, cu_reg})
            rel_calc = REL_DISJOINT;
        else
            rel_calc = REL_CONFUSED;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (!cmd.has_element)
                        state_next = ST_FINISH;
                    else if (fill_reg == '0)
                        state_next = ST_INSERT;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (match)
                    state_next = ST_FINISH;
                else if (scan_last)
                    state_next = ST_INSERT;
            end
            ST_INSERT: state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (!cur_reg.end_of_pair || can_emit)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cur_next    = cur_reg;
        idx_next    = idx_reg;
        fill_next   = fill_reg;
        cf_next     = cf_reg;
        cs_next     = cs_reg;
        cu_next     = cu_reg;
        ovf_next    = ovf_reg;
        ovalid_next = ovalid_reg && !results.ready;
        rel_next    = rel_reg;
        oovf_next   = oovf_reg;
        cmd_pop     = 1'b0;
        ram_we      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (cmd_valid)
                begin
                    cmd_pop  = 1'b1;
                    cur_next = cmd;
                    if (cmd.has_element)
                    begin
                        if (cmd.in_second_set)
                        begin
                            if (cs_reg >= LIMIT) ovf_next = 1'b1;
                            else cs_next = cs_reg + CW'(1);
                        end
                        else
                        begin
                            if (cf_reg >= LIMIT) ovf_next = 1'b1;
                            else cf_next = cf_reg + CW'(1);
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if (!match && !scan_last)
                    idx_next = idx_reg + AW'(1);
            end
            ST_INSERT:
            begin
                if (table_full)
                    ovf_next = 1'b1;
                else
                begin
                    ram_we    = 1'b1;
                    fill_next = fill_reg + FW'(1);
                    cu_next   = cu_reg + CW'(1);
                end
            end
            ST_FINISH:
            begin
                if (cur_reg.end_of_pair && can_emit)
                begin
                    ovalid_next = 1'b1;
                    rel_next    = rel_calc;
                    oovf_next   = ovf_reg;
                    fill_next   = '0;
                    cf_next     = '0;
                    cs_next     = '0;
                    cu_next     = '0;
                    ovf_next    = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            idx_reg    <= '0;
            fill_reg   <= '0;
            cf_reg     <= '0;
            cs_reg     <= '0;
            cu_reg     <= '0;
            ovf_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            fill_reg   <= fill_next;
            cf_reg     <= cf_next;
            cs_reg     <= cs_next;
            cu_reg     <= cu_next;
            ovf_reg    <= ovf_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        rel_reg  <= rel_next;
        oovf_reg <= oovf_next;
    end

    a_union_fill: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cu_reg) == 32'(fill_reg))
        else $error("union count and table fill disagree");
    a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= CAP)
        else $error("table fill past capacity");
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FINISH && cur_reg.end_of_pair && can_emit
        |=> cf_reg == '0 && cs_reg == '0 && !ovf_reg && results.valid)
        else $error("pair not cleared after result");
endmodule
`default_nettype wire

// ----- sv/set_relation_classifier.sv -----
// Top level of the set relation classifier.
// Elements of set A then set B arrive one word each; every element is looked up
// in a table of distinct values by a linear scan of one on-chip RAM entry per
// cycle, so a word with an element takes longer the more distinct values are
// stored so far in the current pair, and less when the value is found early in
// the scan. An empty word that closes the pair goes straight to the finish step,
// and an empty word that does not close it is dropped at the input. If an earlier
// result has not yet been taken, a closing word waits in its last step until the
// result register frees up. A two-word input queue lets new words land while
// the scan runs, and a result register holds the classification until it is
// taken. The table is emptied at the end of each pair by resetting its fill
// count, so no clearing pass is needed and the block is ready right after
// reset.
`default_nettype none
module set_relation_classifier
    import srel_pkg::*;
#(
    parameter int TABLE_CAPACITY = 128,
    parameter int COUNT_LIMIT    = 255
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    srel_item_if.sink     items,
    srel_result_if.source results
);
    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;

    srel_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    srel_back #(
        .TABLE_CAPACITY (TABLE_CAPACITY),
        .COUNT_LIMIT    (COUNT_LIMIT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .results   (results)
    );
endmodule
`default_nettype wire

// ----- test/tb_set_relation_classifier.sv -----
// Testbench for the set relation classifier: directed table plus random pairs, checked by a predictor.
`timescale 1ns / 1ps
module tb_set_relation_classifier;
    import srel_pkg::*;

    localparam int TableCap   = 128;
    localparam int CountLimit = 255;
    localparam int CycleLimit = 1000000;

    typedef struct {
        logic [31:0] element;
        logic        second;
        logic        has;
        logic        last;
        logic        check_typed;
        relation_t   rel_typed;
        logic        ovf_typed;
    } stim_row_t;

    typedef struct packed {
        relation_t rel;
        logic      ovf;
    } verdict_t;

    logic clk;
    logic rst_n;
    srel_item_if   items ();
    srel_result_if results ();

    set_relation_classifier dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items.sink),
        .results (results.source)
    );

    logic [31:0] pred_values[$];
    int          pred_count_a;
    int          pred_count_b;
    logic        pred_overflow;
    verdict_t    verdict_queue[$];
    int          mismatches;
    int          verdicts_seen;
    int          items_sent;
    int          cycle_count;
    int          hold_cycles;
    int          overflow_pairs;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_set_relation_classifier NOT OK");
            $finish;
        end
    end

    function automatic verdict_t predict_pair_step(logic [31:0] element, logic second,
                                                   logic has, logic last);
        verdict_t v;
        bit       found;
        int       u;
        v = '0;
        if (has)
        begin
            if (second)
            begin
                if (pred_count_b >= CountLimit) pred_overflow = 1'b1;
                else pred_count_b++;
            end
            else
            begin
                if (pred_count_a >= CountLimit) pred_overflow = 1'b1;
                else pred_count_a++;
            end
            found = 1'b0;
            foreach (pred_values[i])
                if (pred_values[i] == element) found = 1'b1;
            if (!found)
            begin
                if (pred_values.size() >= TableCap || pred_values.size() >= CountLimit)
                    pred_overflow = 1'b1;
                else
                    pred_values = {pred_values, element};
            end
        end
        if (last)
        begin
            u = pred_values.size();
            if (pred_count_a == pred_count_b && pred_count_b == u) v.rel = REL_EQUAL;
            else if (u == pred_count_a && pred_count_b < pred_count_a) v.rel = REL_B_IN_A;
            else if (u == pred_count_b && pred_count_a < pred_count_b) v.rel = REL_A_IN_B;
            else if (pred_count_a + pred_count_b == u) v.rel = REL_DISJOINT;
            else v.rel = REL_CONFUSED;
            v.ovf = pred_overflow;
            pred_values.delete();
            pred_count_a  = 0;
            pred_count_b  = 0;
            pred_overflow = 1'b0;
        end
        return v;
    endfunction

    task automatic send_word(stim_row_t row);
        verdict_t v;
        int       idle;
        idle = $urandom_range(0, 3);
        if (idle > 0)
        begin
            items.valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        items.valid         <= 1'b1;
        items.element       <= row.element;
        items.in_second_set <= row.second;
        items.has_element   <= row.has;
        items.end_of_pair   <= row.last;
        @(posedge clk);
        while (!items.ready) @(posedge clk);
        items_sent++;
        v = predict_pair_step(row.element, row.second, row.has, row.last);
        if (row.last)
        begin
            if (row.check_typed && (v.rel != row.rel_typed || v.ovf != row.ovf_typed))
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("table row disagrees with predictor: rel %0d ovf %0b",
                             v.rel, v.ovf);
            end
            if (v.ovf) overflow_pairs++;
            verdict_queue = {verdict_queue, v};
        end
    endtask

    task automatic send_elem(logic [31:0] e, logic second, logic last);
        stim_row_t row;
        row = '{e, second, 1'b1, last, 1'b0, REL_EQUAL, 1'b0};
        send_word(row);
    endtask

    task automatic send_random_pair(int size_a, int size_b, int mode);
        logic [31:0] pool[$];
        logic [31:0] e;
        int          n;
        for (int i = 0; i < size_a; i++)
        begin
            e = (mode == 3) ? 32'($urandom_range(0, 7)) : $urandom;
            pool = {pool, e};
            send_elem(e, 1'b0, 1'b0);
        end
        n = 0;
        for (int i = 0; i < size_b; i++)
        begin
            if (mode == 0 && pool.size() > 0 && n < pool.size()) e = pool[n++];
            else if (mode == 1 && pool.size() > 0 && $urandom_range(0, 1))
                e = pool[$urandom_range(0, pool.size() - 1)];
            else if (mode == 3) e = 32'($urandom_range(0, 7));
            else e = $urandom;
            if (i == size_b - 1 && $urandom_range(0, 1))
            begin
                send_elem(e, 1'b1, 1'b1);
                return;
            end
            send_elem(e, 1'b1, 1'b0);
        end
        send_word('{$urandom, 1'($urandom), 1'b0, 1'b1, 1'b0, REL_EQUAL, 1'b0});
    endtask

    task automatic check_verdict(relation_t rel, logic ovf);
        verdict_t want;
        verdicts_seen++;
        if (verdict_queue.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected verdict rel %0d ovf %0b", rel, ovf);
            return;
        end
        want = verdict_queue.pop_front();
        if (rel !== want.rel || ovf !== want.ovf)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("verdict %0d: expected rel %0d ovf %0b, got rel %0d ovf %0b",
                         verdicts_seen, want.rel, want.ovf, rel, ovf);
        end
    endtask

    initial
    begin
        stim_row_t directed[$];
        int        n_items;
        rst_n               = 1'b0;
        items.valid         = 1'b0;
        items.element       = '0;
        items.in_second_set = 1'b0;
        items.has_element   = 1'b0;
        items.end_of_pair   = 1'b0;
        cycle_count    = 0;
        mismatches     = 0;
        verdicts_seen  = 0;
        items_sent     = 0;
        overflow_pairs = 0;
        hold_cycles    = 0;
        pred_count_a   = 0;
        pred_count_b   = 0;
        pred_overflow  = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed = '{
            '{32'h0,        1'b0, 1'b0, 1'b1, 1'b1, REL_EQUAL,    1'b0},
            '{32'h8000_0000, 1'b0, 1'b1, 1'b0, 1'b0, REL_EQUAL,    1'b0},
            '{32'h8000_0000, 1'b1, 1'b1, 1'b1, 1'b1, REL_EQUAL,    1'b0},
            '{32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b0, REL_EQUAL,    1'b0},
            '{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b0, REL_EQUAL,    1'b0},
            '{32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0, REL_EQUAL,    1'b0},
            '{32'h0,        1'b1, 1'b0, 1'b1, 1'b1, REL_B_IN_A,   1'b0},
            '{32'h5,        1'b0, 1'b1, 1'b0, 1'b0, REL_EQUAL,    1'b0},
            '{32'h5,        1'b1, 1'b1, 1'b0, 1'b0, REL_EQUAL,    1'b0},
            '{32'h6,        1'b1, 1'b1, 1'b1, 1'b1, REL_A_IN_B,   1'b0},
            '{32'h1,        1'b0, 1'b1, 1'b0, 1'b0, REL_EQUAL,    1'b0},
            '{32'h2,        1'b1, 1'b1, 1'b1, 1'b1, REL_DISJOINT, 1'b0},
            '{32'h1,        1'b0, 1'b1, 1'b0, 1'b0, REL_EQUAL,    1'b0},
            '{32'h2,        1'b0, 1'b1, 1'b0, 1'b0, REL_EQUAL,    1'b0},
            '{32'h2,        1'b1, 1'b1, 1'b0, 1'b0, REL_EQUAL,    1'b0},
            '{32'h3,        1'b1, 1'b1, 1'b1, 1'b1, REL_CONFUSED, 1'b0},
            '{32'h9,        1'b0, 1'b1, 1'b0, 1'b0, REL_EQUAL,    1'b0},
            '{32'h9,        1'b0, 1'b1, 1'b1, 1'b0, REL_EQUAL,    1'b0},
            '{32'h0,        1'b1, 1'b0, 1'b1, 1'b1, REL_EQUAL,    1'b0}
        };
        foreach (directed[i]) send_word(directed[i]);

        // overflow: full table, then count limit with repeats
        for (int i = 0; i < TableCap + 2; i++) send_elem(32'(i) ^ 32'hA5A5_0000, 1'b0, 1'b0);
        send_elem(32'h1234, 1'b1, 1'b1);
        for (int i = 0; i < CountLimit + 3; i++) send_elem(32'(i % 4), 1'b0, 1'b0);
        send_elem(32'h1, 1'b1, 1'b1);

        n_items = items_sent;
        while (items_sent < n_items + 1290)
        begin
            case ($urandom_range(0, 9))
                0: send_random_pair($urandom_range(0, 2), $urandom_range(0, 2), 2);
                1, 2: send_random_pair($urandom_range(0, 8), $urandom_range(0, 8), 0);
                3, 4: send_random_pair($urandom_range(0, 8), $urandom_range(0, 8), 1);
                5, 6: send_random_pair($urandom_range(0, 10), $urandom_range(0, 10), 2);
                7: send_random_pair($urandom_range(1, 6), $urandom_range(1, 6), 3);
                8: send_word('{$urandom, 1'($urandom), 1'($urandom), 1'b0,
                               1'b0, REL_EQUAL, 1'b0});
                default: send_random_pair($urandom_range(20, 40), $urandom_range(20, 40), 1);
            endcase
        end
        items.valid <= 1'b0;
        while (verdict_queue.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        $display("%0d words sent, %0d verdicts checked, %0d overflow pairs",
                 items_sent, verdicts_seen, overflow_pairs);
        if (mismatches == 0 && verdict_queue.size() == 0)
            $display("tb_set_relation_classifier OK");
        else
            $display("tb_set_relation_classifier NOT OK");
        $finish;
    end

    initial
    begin
        int wait_cycles;
        results.ready = 1'b0;
        @(posedge rst_n);
        while (1)
        begin
            if (verdicts_seen == 3 && hold_cycles == 0)
            begin
                results.ready <= 1'b0;
                for (hold_cycles = 1; hold_cycles <= 400; hold_cycles++) @(posedge clk);
            end
            if (verdicts_seen > 40 && verdicts_seen < 80)
                results.ready <= 1'b1;
            else
            begin
                wait_cycles = $urandom_range(0, 3);
                if (wait_cycles > 0)
                begin
                    results.ready <= 1'b0;
                    repeat (wait_cycles) @(posedge clk);
                end
                results.ready <= 1'b1;
            end
            @(posedge clk);
            while (!results.valid) @(posedge clk);
            check_verdict(relation_t'(results.relation), results.overflowed);
        end
    end
endmodule
